>>> design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is low.
`define TLR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off while reset is low.
`define TLR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/tlr_pkg.sv
`default_nettype none

package tlr_pkg;

    // Field widths.
    localparam int COORD_BITS    = 16;
    localparam int PIX_BITS      = COORD_BITS + 1;
    localparam int COLOR_BITS    = 32;
    localparam int WIDTH_BITS    = 6;
    localparam int MAX_PEN_WIDTH = 63;

    // Internal widths: Bresenham error terms and disc state.
    localparam int ERR_BITS  = PIX_BITS + 1;
    localparam int DISC_BITS = WIDTH_BITS + 1;
    localparam int DERR_BITS = DISC_BITS + 2;

    // Stream word widths, padded to whole bytes.
    localparam int S_FIELD_BITS = 4 * COORD_BITS + COLOR_BITS + WIDTH_BITS;
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = 2 * PIX_BITS + COLOR_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    // Input word kind carried in tuser.
    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    // Which row offset a write uses, relative to the disc center.
    typedef enum logic [1:0] {
        SPAN_UP_Y = 2'd0,
        SPAN_DN_Y = 2'd1,
        SPAN_UP_X = 2'd2,
        SPAN_DN_X = 2'd3
    } t_span_sel;

    // Datapath update issued with an emitted write.
    typedef enum logic [2:0] {
        ACT_HOLD       = 3'd0,
        ACT_INC        = 3'd1,
        ACT_TO_TOP     = 3'd2,
        ACT_NEW_ROW    = 3'd3,
        ACT_NEXT_POINT = 3'd4
    } t_act;

    typedef struct packed {
        logic      load;
        logic      setup;
        logic      emit;
        logic      last;
        t_span_sel sel;
        t_act      act;
    } t_dp_cmd;

    typedef struct packed {
        logic over_x;
        logic over_y;
        logic disc_more;
        logic line_end;
    } t_dp_status;

endpackage

`default_nettype wire

>>> design/tlr_ctrl.sv
`default_nettype none

module tlr_ctrl import tlr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  t_op        i_op,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_PH0   = 6'b000100,
        ST_PH1   = 6'b001000,
        ST_PH2   = 6'b010000,
        ST_PH3   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_take;
    logic   w_busy;

    // Input is taken, outside the setup state, whenever the output slot is free or being emptied.
    assign s_axis_tready = (r_state != ST_SETUP) && (!r_out_valid || m_axis_tready);
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign w_busy        = (r_state == ST_PH0) || (r_state == ST_PH1) ||
                           (r_state == ST_PH2) || (r_state == ST_PH3);

    // Next state and datapath command.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !m_axis_tready;
        o_cmd       = '0;
        o_cmd.sel   = SPAN_UP_Y;
        o_cmd.act   = ACT_HOLD;

        case (r_state)
            ST_PH1: begin
                o_cmd.sel = SPAN_DN_Y;
            end
            ST_PH2: begin
                o_cmd.sel = SPAN_UP_X;
            end
            ST_PH3: begin
                o_cmd.sel = SPAN_DN_X;
            end
            default: begin
                o_cmd.sel = SPAN_UP_Y;
            end
        endcase

        if (r_state == ST_SETUP) begin
            o_cmd.setup = 1'b1;
            n_state     = ST_PH0;
        end

        if (w_take && (i_op == OP_START)) begin
            o_cmd.load = 1'b1;
            n_state    = ST_SETUP;
        end else if (w_take && w_busy) begin
            o_cmd.emit  = 1'b1;
            n_out_valid = 1'b1;
            case (r_state)
                ST_PH0: begin
                    n_state = ST_PH1;
                end
                ST_PH1: begin
                    if (i_status.over_x) begin
                        o_cmd.act = ACT_TO_TOP;
                        n_state   = ST_PH2;
                    end else begin
                        o_cmd.act = ACT_INC;
                        n_state   = ST_PH0;
                    end
                end
                ST_PH2: begin
                    n_state = ST_PH3;
                end
                ST_PH3: begin
                    if (!i_status.over_y) begin
                        o_cmd.act = ACT_INC;
                        n_state   = ST_PH2;
                    end else if (i_status.disc_more) begin
                        o_cmd.act = ACT_NEW_ROW;
                        n_state   = ST_PH0;
                    end else if (i_status.line_end) begin
                        o_cmd.last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        o_cmd.act = ACT_NEXT_POINT;
                        n_state   = ST_PH0;
                    end
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end
    end

    // State and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

>>> design/tlr_datapath.sv
`default_nettype none

module tlr_datapath import tlr_pkg::*; (
    input  logic                        i_clk,
    input  logic signed [COORD_BITS-1:0] i_from_x,
    input  logic signed [COORD_BITS-1:0] i_from_y,
    input  logic signed [COORD_BITS-1:0] i_to_x,
    input  logic signed [COORD_BITS-1:0] i_to_y,
    input  logic [COLOR_BITS-1:0]       i_pen_color,
    input  logic [WIDTH_BITS-1:0]       i_pen_width,
    input  t_dp_cmd                     i_cmd,
    output t_dp_status                  o_status,
    output logic signed [PIX_BITS-1:0]  o_pix_x,
    output logic signed [PIX_BITS-1:0]  o_pix_y,
    output logic [COLOR_BITS-1:0]       o_pix_color,
    output logic                        o_last
);

    // Captured start command.
    logic signed [COORD_BITS-1:0] r_fx, r_fy, r_tx, r_ty;
    logic [COORD_BITS-1:0]        r_dx, r_dy;
    logic                         r_x_neg, r_y_neg, r_x_eq, r_y_eq;
    logic [WIDTH_BITS-1:0]        r_radius;
    logic [COLOR_BITS-1:0]        r_color;

    // Line stepping state.
    logic                       r_steep;
    logic signed [PIX_BITS-1:0] r_cur_major, r_cur_minor, r_end_major;
    logic signed [1:0]          r_minor_step;
    logic [ERR_BITS-1:0]        r_line_error, r_err_inc, r_err_thr;
    logic [ERR_BITS-1:0]        r_bres_sum;
    logic signed [PIX_BITS-1:0] r_minor_mv;

    // Disc state; the span offset is relative to the disc center x.
    logic signed [DISC_BITS-1:0] r_disc_x, r_disc_y, r_span_off;
    logic signed [DERR_BITS-1:0] r_disc_err;

    // Output word.
    logic signed [PIX_BITS-1:0] r_pix_x, r_pix_y;
    logic [COLOR_BITS-1:0]      r_pix_color;
    logic                       r_last;

    logic signed [COORD_BITS:0]   w_dx_p, w_dx_m, w_dy_p, w_dy_m;
    logic [WIDTH_BITS-1:0]        w_width;
    logic                         w_steep, w_swap, w_minor_eq, w_minor_neg;
    logic signed [COORD_BITS-1:0] w_fmaj, w_tmaj, w_fmin;
    logic [COORD_BITS-1:0]        w_dmaj, w_dmin;
    logic signed [1:0]            w_minor_step;
    logic [ERR_BITS-1:0]          w_inc;
    logic signed [DISC_BITS-1:0]  w_rad_s;
    logic signed [DISC_BITS-1:0]  w_dx1, w_dy1;
    logic signed [DERR_BITS-1:0]  w_de1;
    logic signed [PIX_BITS-1:0]   w_cx, w_cy, w_py;
    logic                         w_ge;

    // Endpoint differences in both directions, picked by sign.
    assign w_dx_p  = (COORD_BITS + 1)'(i_to_x) - (COORD_BITS + 1)'(i_from_x);
    assign w_dx_m  = (COORD_BITS + 1)'(i_from_x) - (COORD_BITS + 1)'(i_to_x);
    assign w_dy_p  = (COORD_BITS + 1)'(i_to_y) - (COORD_BITS + 1)'(i_from_y);
    assign w_dy_m  = (COORD_BITS + 1)'(i_from_y) - (COORD_BITS + 1)'(i_to_y);
    assign w_width = (i_pen_width > WIDTH_BITS'(MAX_PEN_WIDTH)) ?
                     WIDTH_BITS'(MAX_PEN_WIDTH) : i_pen_width;

    // Major axis choice and endpoint ordering.
    always_comb begin
        w_steep      = r_dy > r_dx;
        w_swap       = w_steep ? r_y_neg : r_x_neg;
        w_fmaj       = w_steep ? (w_swap ? r_ty : r_fy) : (w_swap ? r_tx : r_fx);
        w_tmaj       = w_steep ? (w_swap ? r_fy : r_ty) : (w_swap ? r_fx : r_tx);
        w_fmin       = w_steep ? (w_swap ? r_tx : r_fx) : (w_swap ? r_ty : r_fy);
        w_dmaj       = w_steep ? r_dy : r_dx;
        w_dmin       = w_steep ? r_dx : r_dy;
        w_minor_eq   = w_steep ? r_x_eq : r_y_eq;
        w_minor_neg  = (w_steep ? r_x_neg : r_y_neg) ^ w_swap;
        w_minor_step = w_minor_eq ? 2'sd0 : (w_minor_neg ? -2'sd1 : 2'sd1);
        w_inc        = ERR_BITS'(w_dmin) + ERR_BITS'(1);
    end

    assign w_rad_s = $signed({1'b0, r_radius});

    // Midpoint circle row advance.
    always_comb begin
        w_dy1 = r_disc_y + DISC_BITS'(1);
        if (r_disc_err < 0) begin
            w_dx1 = r_disc_x;
            w_de1 = r_disc_err + (DERR_BITS'(w_dy1) <<< 1) + DERR_BITS'(1);
        end else begin
            w_dx1 = r_disc_x - DISC_BITS'(1);
            w_de1 = r_disc_err +
                    ((DERR_BITS'(w_dy1) - DERR_BITS'(w_dx1) + DERR_BITS'(1)) <<< 1);
        end
    end

    // Disc center and the row of the current write.
    assign w_cx = r_steep ? r_cur_minor : r_cur_major;
    assign w_cy = r_steep ? r_cur_major : r_cur_minor;

    always_comb begin
        case (i_cmd.sel)
            SPAN_UP_Y: w_py = w_cy - PIX_BITS'(r_disc_y);
            SPAN_DN_Y: w_py = w_cy + PIX_BITS'(r_disc_y);
            SPAN_UP_X: w_py = w_cy - PIX_BITS'(r_disc_x);
            SPAN_DN_X: w_py = w_cy + PIX_BITS'(r_disc_x);
            default:   w_py = w_cy;
        endcase
    end

    assign w_ge = r_bres_sum >= r_err_thr;

    assign o_status.over_x    = r_span_off >= r_disc_x;
    assign o_status.over_y    = r_span_off >= r_disc_y;
    assign o_status.disc_more = w_dx1 >= w_dy1;
    assign o_status.line_end  = r_cur_major >= r_end_major;

    // Capture of a start command.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fx     <= i_from_x;
            r_fy     <= i_from_y;
            r_tx     <= i_to_x;
            r_ty     <= i_to_y;
            r_dx     <= w_dx_p[COORD_BITS] ? w_dx_m[COORD_BITS-1:0] : w_dx_p[COORD_BITS-1:0];
            r_dy     <= w_dy_p[COORD_BITS] ? w_dy_m[COORD_BITS-1:0] : w_dy_p[COORD_BITS-1:0];
            r_x_neg  <= w_dx_p[COORD_BITS];
            r_y_neg  <= w_dy_p[COORD_BITS];
            r_x_eq   <= i_to_x == i_from_x;
            r_y_eq   <= i_to_y == i_from_y;
            r_radius <= w_width >> 1;
            r_color  <= i_pen_color;
        end
    end

    // Next-point error sum and moved minor coordinate, registered ahead of their use.
    always_ff @(posedge i_clk) begin
        r_bres_sum <= r_line_error + r_err_inc;
        r_minor_mv <= r_cur_minor + PIX_BITS'(r_minor_step);
    end

    // Line and disc stepping.
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_steep      <= w_steep;
            r_cur_major  <= PIX_BITS'(w_fmaj);
            r_cur_minor  <= PIX_BITS'(w_fmin);
            r_end_major  <= PIX_BITS'(w_tmaj);
            r_minor_step <= w_minor_step;
            r_err_inc    <= w_inc;
            r_err_thr    <= ERR_BITS'(w_dmaj) + ERR_BITS'(1);
            r_line_error <= w_inc >> 1;
            r_disc_x     <= w_rad_s;
            r_disc_y     <= '0;
            r_disc_err   <= DERR_BITS'(1) - DERR_BITS'(w_rad_s);
            r_span_off   <= -w_rad_s;
        end else if (i_cmd.emit) begin
            case (i_cmd.act)
                ACT_INC: begin
                    r_span_off <= r_span_off + DISC_BITS'(1);
                end
                ACT_TO_TOP: begin
                    r_span_off <= -r_disc_y;
                end
                ACT_NEW_ROW: begin
                    r_disc_x   <= w_dx1;
                    r_disc_y   <= w_dy1;
                    r_disc_err <= w_de1;
                    r_span_off <= -w_dx1;
                end
                ACT_NEXT_POINT: begin
                    r_line_error <= w_ge ? (r_bres_sum - r_err_thr) : r_bres_sum;
                    r_cur_minor  <= w_ge ? r_minor_mv : r_cur_minor;
                    r_cur_major  <= r_cur_major + PIX_BITS'(1);
                    r_disc_x     <= w_rad_s;
                    r_disc_y     <= '0;
                    r_disc_err   <= DERR_BITS'(1) - DERR_BITS'(w_rad_s);
                    r_span_off   <= -w_rad_s;
                end
                default: begin
                    r_span_off <= r_span_off;
                end
            endcase
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pix_x     <= w_cx + PIX_BITS'(r_span_off);
            r_pix_y     <= w_py;
            r_pix_color <= r_color;
            r_last      <= i_cmd.last;
        end
    end

    assign o_pix_x     = r_pix_x;
    assign o_pix_y     = r_pix_y;
    assign o_pix_color = r_pix_color;
    assign o_last      = r_last;

endmodule

`default_nettype wire

>>> design/thick_line_rasterizer_core.sv
// Channel   Dir  Word contents
// s_axis    in   tuser: op (0 start, 1 step); tdata: from_x, from_y, to_x, to_y,
//                pen_color, pen_width
// m_axis    out  tdata: pix_x, pix_y, pix_color; tlast: final write of the line
//
// A step word yields one pixel write and is taken every cycle while the output
// register is free or drained in the same cycle, so writes stream at one a cycle.
// The cycle after a start word orders the endpoints, and the input is not ready
// then. Reset is synchronous, active low, and leaves the block
// idle; a step word taken while idle yields nothing. A stalled output word holds
// its value and blocks the input until it is taken.
`default_nettype none

module thick_line_rasterizer_core import tlr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // from_x, from_y, to_x, to_y, pen_color, pen_width, zero fill
    input  logic [S_TDATA_BITS-1:0] s_axis_tdata,
    // op
    input  logic                    s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // pix_x, pix_y, pix_color, zero fill
    output logic [M_TDATA_BITS-1:0] m_axis_tdata,
    output logic                    m_axis_tlast
);

    t_dp_cmd                    w_cmd;
    t_dp_status                 w_status;
    logic signed [PIX_BITS-1:0] w_pix_x, w_pix_y;
    logic [COLOR_BITS-1:0]      w_pix_color;

    // Sequencer for disc spans and line points.
    tlr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_op          (t_op'(s_axis_tuser)),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_status      (w_status),
        .o_cmd         (w_cmd)
    );

    // Coordinate arithmetic and output word.
    tlr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_from_x    (s_axis_tdata[COORD_BITS-1:0]),
        .i_from_y    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_to_x      (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_to_y      (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .i_pen_color (s_axis_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS]),
        .i_pen_width (s_axis_tdata[S_FIELD_BITS-1:4*COORD_BITS+COLOR_BITS]),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_pix_x     (w_pix_x),
        .o_pix_y     (w_pix_y),
        .o_pix_color (w_pix_color),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = M_TDATA_BITS'({w_pix_color, w_pix_y, w_pix_x});

endmodule

`default_nettype wire

>>> design/tlr_checker.sv
`default_nettype none
`include "assert_macros.svh"

module tlr_checker import tlr_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    s_axis_tvalid,
    input logic                    s_axis_tready,
    input logic                    s_axis_tuser,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [M_TDATA_BITS-1:0] m_axis_tdata,
    input logic                    m_axis_tlast
);

    logic w_out_stall;
    logic w_start_taken;

    // Handshake events watched by the checks below.
    assign w_out_stall   = m_axis_tvalid && !m_axis_tready;
    assign w_start_taken = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_START);

    // A waiting output word stays and keeps its value.
    `TLR_ASSERT_NEXT(a_out_hold, w_out_stall, m_axis_tvalid && $stable({m_axis_tlast, m_axis_tdata}))

    // No input word is taken while an output word is stalled.
    `TLR_ASSERT_NOW(a_in_blocked, w_out_stall, !s_axis_tready)

    // The cycle after a start the input pauses for endpoint ordering.
    `TLR_ASSERT_NEXT(a_start_gap, w_start_taken, !s_axis_tready)

    // A start never produces an output word of its own.
    `TLR_ASSERT_NEXT(a_start_silent, w_start_taken, !m_axis_tvalid || $past(m_axis_tvalid))

endmodule

bind thick_line_rasterizer_core tlr_checker u_tlr_checker (.*);

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tlr_pkg::*;

    localparam int RANDOM_WORDS = 650;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 16;

    // How a stimulus word is checked.
    typedef enum logic [1:0] {
        CHK_PRED  = 2'd0,
        CHK_NONE  = 2'd1,
        CHK_TYPED = 2'd2
    } t_chk;

    typedef struct packed {
        t_op                           op;
        logic signed [COORD_BITS-1:0]  fx;
        logic signed [COORD_BITS-1:0]  fy;
        logic signed [COORD_BITS-1:0]  tx;
        logic signed [COORD_BITS-1:0]  ty;
        logic [COLOR_BITS-1:0]         color;
        logic [WIDTH_BITS-1:0]         width;
    } t_word;

    typedef struct packed {
        logic signed [PIX_BITS-1:0] x;
        logic signed [PIX_BITS-1:0] y;
        logic [COLOR_BITS-1:0]      color;
        logic                       last;
    } t_pix_write;

    typedef struct packed {
        t_word      w;
        t_chk       chk;
        t_pix_write wr;
    } t_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // from_x, from_y, to_x, to_y, pen_color, pen_width, zero fill
    logic [S_TDATA_BITS-1:0] s_axis_tdata;
    // op
    logic                    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // pix_x, pix_y, pix_color, zero fill
    logic [M_TDATA_BITS-1:0] m_axis_tdata;
    logic                    m_axis_tlast;

    thick_line_rasterizer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Line stepper and disc filler state of the predictor.
    bit                    ln_busy;
    bit                    ln_steep;
    int                    cur_maj;
    int                    cur_min;
    int                    end_maj;
    int                    min_dir;
    int                    err_acc;
    int                    err_inc;
    int                    err_lim;
    int                    pen_r;
    int                    dsc_x;
    int                    dsc_y;
    int                    dsc_err;
    int                    run_pos;
    t_span_sel             run_phase;
    logic [COLOR_BITS-1:0] ln_color;

    t_pix_write pix_expect[$];

    int fail_count;
    int cycle_count;
    int items_sent;
    int n_starts;
    int n_restarts;
    int n_idle_steps;
    int n_writes;
    int n_lines_done;
    int send_idle_pct;
    int sink_stall_pct;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int center_x();
        return ln_steep ? cur_min : cur_maj;
    endfunction

    // Starts the disc at the current line point: center row, widest span.
    task automatic disc_start();
        dsc_x     = pen_r;
        dsc_y     = 0;
        dsc_err   = 1 - pen_r;
        run_phase = SPAN_UP_Y;
        run_pos   = center_x() - dsc_x;
    endtask

    // Advances the predictor by one accepted word and gives the write it causes.
    task automatic line_predict(input t_word w, output bit made, output t_pix_write wr);
        int fx, fy, tx, ty, dx, dy;
        int fmaj, fmin, tmaj, tmin, dmaj, dmin, swap_tmp;
        int cx, cy, py;
        made = 1'b0;
        wr   = '0;
        if (w.op == OP_START) begin
            fx = w.fx;
            fy = w.fy;
            tx = w.tx;
            ty = w.ty;
            dx = (tx > fx) ? tx - fx : fx - tx;
            dy = (ty > fy) ? ty - fy : fy - ty;
            ln_steep = dy > dx;
            if (ln_steep) begin
                fmaj = fy; fmin = fx; tmaj = ty; tmin = tx; dmaj = dy; dmin = dx;
            end else begin
                fmaj = fx; fmin = fy; tmaj = tx; tmin = ty; dmaj = dx; dmin = dy;
            end
            // Walk the major axis upward.
            if (fmaj > tmaj) begin
                swap_tmp = fmaj; fmaj = tmaj; tmaj = swap_tmp;
                swap_tmp = fmin; fmin = tmin; tmin = swap_tmp;
            end
            cur_maj  = fmaj;
            cur_min  = fmin;
            end_maj  = tmaj;
            min_dir  = (tmin > fmin) ? 1 : ((tmin < fmin) ? -1 : 0);
            err_inc  = dmin + 1;
            err_lim  = dmaj + 1;
            err_acc  = err_inc / 2;
            pen_r    = ((w.width > MAX_PEN_WIDTH) ? MAX_PEN_WIDTH : int'(w.width)) / 2;
            ln_color = w.color;
            ln_busy  = 1'b1;
            disc_start();
        end else if (ln_busy) begin
            cx = center_x();
            cy = ln_steep ? cur_maj : cur_min;
            case (run_phase)
                SPAN_UP_Y: py = cy - dsc_y;
                SPAN_DN_Y: py = cy + dsc_y;
                SPAN_UP_X: py = cy - dsc_x;
                default:   py = cy + dsc_x;
            endcase
            made     = 1'b1;
            wr.x     = run_pos[PIX_BITS-1:0];
            wr.y     = py[PIX_BITS-1:0];
            wr.color = ln_color;
            wr.last  = 1'b0;
            case (run_phase)
                SPAN_UP_Y: run_phase = SPAN_DN_Y;
                SPAN_UP_X: run_phase = SPAN_DN_X;
                SPAN_DN_Y: begin
                    // Wide spans sit dsc_y rows off the center.
                    run_pos++;
                    if (run_pos > cx + dsc_x) begin
                        run_phase = SPAN_UP_X;
                        run_pos   = cx - dsc_y;
                    end else begin
                        run_phase = SPAN_UP_Y;
                    end
                end
                default: begin
                    run_pos++;
                    if (run_pos > cx + dsc_y) begin
                        // Midpoint update of the disc outline.
                        dsc_y++;
                        if (dsc_err < 0) begin
                            dsc_err += 2 * dsc_y + 1;
                        end else begin
                            dsc_x--;
                            dsc_err += 2 * (dsc_y - dsc_x + 1);
                        end
                        if (dsc_x >= dsc_y) begin
                            run_phase = SPAN_UP_Y;
                            run_pos   = cx - dsc_x;
                        end else if (cur_maj >= end_maj) begin
                            wr.last = 1'b1;
                            ln_busy = 1'b0;
                        end else begin
                            // Bresenham step to the next line point.
                            err_acc += err_inc;
                            if (err_acc >= err_lim) begin
                                cur_min += min_dir;
                                err_acc -= err_lim;
                            end
                            cur_maj++;
                            disc_start();
                        end
                    end else begin
                        run_phase = SPAN_UP_X;
                    end
                end
            endcase
        end
    endtask

    function automatic t_row start_row(int fx, int fy, int tx, int ty,
                                       logic [COLOR_BITS-1:0] color, int width, t_chk chk);
        t_row r;
        r          = '0;
        r.w.op     = OP_START;
        r.w.fx     = fx[COORD_BITS-1:0];
        r.w.fy     = fy[COORD_BITS-1:0];
        r.w.tx     = tx[COORD_BITS-1:0];
        r.w.ty     = ty[COORD_BITS-1:0];
        r.w.color  = color;
        r.w.width  = width[WIDTH_BITS-1:0];
        r.chk      = chk;
        return r;
    endfunction

    function automatic t_row step_row(t_chk chk, int x, int y,
                                      logic [COLOR_BITS-1:0] color, bit last);
        t_row r;
        r           = '0;
        r.w.op      = OP_STEP;
        r.chk       = chk;
        r.wr.x      = x[PIX_BITS-1:0];
        r.wr.y      = y[PIX_BITS-1:0];
        r.wr.color  = color;
        r.wr.last   = last;
        return r;
    endfunction

    function automatic t_word rand_word(t_op op);
        t_word w;
        w.op    = op;
        w.fx    = COORD_BITS'($urandom);
        w.fy    = COORD_BITS'($urandom);
        w.tx    = COORD_BITS'($urandom);
        w.ty    = COORD_BITS'($urandom);
        w.color = $urandom;
        w.width = WIDTH_BITS'($urandom_range(0, 63));
        return w;
    endfunction

    // Offers one word, waits for it to be taken, then updates the predictor.
    // Entered and left at a falling edge.
    task automatic send_word(input t_word w, input t_chk chk, input t_pix_write typed);
        bit         made;
        bit         was_busy;
        t_pix_write wr;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  = S_TDATA_BITS'({w.width, w.color, w.ty, w.tx, w.fy, w.fx});
        s_axis_tuser  = w.op;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        was_busy = ln_busy;
        line_predict(w, made, wr);
        if (w.op == OP_START) begin
            n_starts++;
            if (was_busy) n_restarts++;
        end
        if (w.op == OP_START || was_busy) items_sent++;
        else n_idle_steps++;
        if (made && wr.last) n_lines_done++;
        case (chk)
            CHK_TYPED: pix_expect.push_back(typed);
            CHK_PRED:  if (made) pix_expect.push_back(wr);
            default:   ;
        endcase
        @(negedge i_clk);
    endtask

    // Output sink: random backpressure.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready = ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Compare every taken pixel write with the oldest expected one.
    always @(posedge i_clk) begin
        t_pix_write got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.x     = m_axis_tdata[PIX_BITS-1:0];
            got.y     = m_axis_tdata[2*PIX_BITS-1:PIX_BITS];
            got.color = m_axis_tdata[2*PIX_BITS+COLOR_BITS-1:2*PIX_BITS];
            got.last  = m_axis_tlast;
            n_writes++;
            if (pix_expect.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected pixel write x=%0d y=%0d color=%h last=%b",
                         $time, got.x, got.y, got.color, got.last);
            end else begin
                want = pix_expect.pop_front();
                if (got.x !== want.x || got.y !== want.y ||
                    got.color !== want.color || got.last !== want.last) begin
                    fail_count++;
                    $display("%0t: pixel write mismatch: expected x=%0d y=%0d color=%h last=%b",
                             $time, want.x, want.y, want.color, want.last);
                    $display("%0t:                       actual   x=%0d y=%0d color=%h last=%b",
                             $time, got.x, got.y, got.color, got.last);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d pixel writes still expected",
                     $time, pix_expect.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_row  plan[$];
        t_word w;
        int    kind;
        int    steps_left;
        int    off_x, off_y, end_x, end_y;

        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        ln_busy        = 1'b0;
        ln_steep       = 1'b0;
        cur_maj        = 0;
        cur_min        = 0;
        end_maj        = 0;
        min_dir        = 0;
        err_acc        = 0;
        err_inc        = 0;
        err_lim        = 0;
        pen_r          = 0;
        dsc_x          = 0;
        dsc_y          = 0;
        dsc_err        = 0;
        run_pos        = 0;
        run_phase      = SPAN_UP_Y;
        ln_color       = '0;
        fail_count     = 0;
        cycle_count    = 0;
        items_sent     = 0;
        n_starts       = 0;
        n_restarts     = 0;
        n_idle_steps   = 0;
        n_writes       = 0;
        n_lines_done   = 0;
        send_idle_pct  = 23;
        sink_stall_pct = 81;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words: idle step, single-point lines at the coordinate corners
        // with a zero-radius pen, widest pen on a full-range diagonal, restart
        // while busy on a steep line, and a reversed horizontal line.
        plan = '{
            step_row(CHK_NONE, 0, 0, '0, 1'b0),
            start_row(-32768, 32767, -32768, 32767, 32'hFFFF_FFFF, 0, CHK_NONE),
            step_row(CHK_TYPED, -32768, 32767, 32'hFFFF_FFFF, 1'b0),
            step_row(CHK_TYPED, -32768, 32767, 32'hFFFF_FFFF, 1'b0),
            step_row(CHK_TYPED, -32768, 32767, 32'hFFFF_FFFF, 1'b0),
            step_row(CHK_TYPED, -32768, 32767, 32'hFFFF_FFFF, 1'b1),
            step_row(CHK_NONE, 0, 0, '0, 1'b0),
            start_row(32767, -32768, 32767, -32768, 32'h0000_0000, 1, CHK_NONE),
            step_row(CHK_TYPED, 32767, -32768, 32'h0000_0000, 1'b0),
            step_row(CHK_TYPED, 32767, -32768, 32'h0000_0000, 1'b0),
            step_row(CHK_TYPED, 32767, -32768, 32'h0000_0000, 1'b0),
            step_row(CHK_TYPED, 32767, -32768, 32'h0000_0000, 1'b1),
            start_row(-32768, -32768, 32767, 32767, 32'h1234_5678, 63, CHK_PRED),
            step_row(CHK_PRED, 0, 0, '0, 1'b0),
            step_row(CHK_PRED, 0, 0, '0, 1'b0),
            step_row(CHK_PRED, 0, 0, '0, 1'b0),
            start_row(0, 100, 3, -20, 32'hA5A5_A5A5, 2, CHK_PRED),
            step_row(CHK_PRED, 0, 0, '0, 1'b0),
            step_row(CHK_PRED, 0, 0, '0, 1'b0),
            step_row(CHK_PRED, 0, 0, '0, 1'b0),
            step_row(CHK_PRED, 0, 0, '0, 1'b0),
            start_row(10, 5, -10, 5, 32'h5A5A_5A5A, 4, CHK_PRED),
            step_row(CHK_PRED, 0, 0, '0, 1'b0),
            step_row(CHK_PRED, 0, 0, '0, 1'b0),
            step_row(CHK_PRED, 0, 0, '0, 1'b0)
        };
        foreach (plan[i]) send_word(plan[i].w, plan[i].chk, plan[i].wr);
        items_sent = 0;

        // Random part, in three idling phases.
        while (items_sent < RANDOM_WORDS) begin
            case (items_sent * 3 / RANDOM_WORDS)
                0: begin send_idle_pct = 23; sink_stall_pct = 81; end
                1: begin send_idle_pct = 81; sink_stall_pct = 23; end
                default: begin send_idle_pct = 0; sink_stall_pct = 0; end
            endcase
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                // Short line run to its end, now and then cut short.
                w     = rand_word(OP_START);
                off_x = $urandom_range(0, 6) - 3;
                off_y = $urandom_range(0, 6) - 3;
                end_x = int'(w.fx) + off_x;
                end_y = int'(w.fy) + off_y;
                if (end_x > 32767 || end_x < -32768) end_x = int'(w.fx) - off_x;
                if (end_y > 32767 || end_y < -32768) end_y = int'(w.fy) - off_y;
                w.tx = end_x[COORD_BITS-1:0];
                w.ty = end_y[COORD_BITS-1:0];
                if ($urandom_range(0, 19) == 0) begin
                    // Single point with a mid-size pen, kept small enough that
                    // one disc stays a modest share of the word count.
                    w.tx    = w.fx;
                    w.ty    = w.fy;
                    w.width = WIDTH_BITS'($urandom_range(8, 15));
                end else begin
                    w.width = WIDTH_BITS'($urandom_range(0, 5));
                end
                send_word(w, CHK_PRED, '0);
                steps_left = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 10) : CYCLE_LIMIT;
                while (ln_busy && steps_left > 0) begin
                    send_word(rand_word(OP_STEP), CHK_PRED, '0);
                    steps_left--;
                end
                if ($urandom_range(0, 99) < 20) send_word(rand_word(OP_STEP), CHK_PRED, '0);
            end else if (kind < 90) begin
                // Random long line, dropped by the next start.
                send_word(rand_word(OP_START), CHK_PRED, '0);
                repeat ($urandom_range(0, 30)) send_word(rand_word(OP_STEP), CHK_PRED, '0);
            end else begin
                // Stray steps, ignored when no line is open.
                repeat ($urandom_range(1, 3)) send_word(rand_word(OP_STEP), CHK_PRED, '0);
            end
        end

        s_axis_tvalid = 1'b0;
        while (pix_expect.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d line starts (%0d while busy) and %0d idle steps; %0d lines finished.",
                 n_starts, n_restarts, n_idle_steps, n_lines_done);
        $display("Checked %0d pixel writes under three backpressure and gap patterns.",
                 n_writes);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
